// File: rtl/core/i2cits_pkg.sv
// shared types, codes and widths for the i2c interrupt transfer sequencer
package i2cits_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 32;

  localparam int CNT_W = 6;
  localparam int LIDX_W = 5;

  // request kinds (tuser on the input side)
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_START_WR = 2'd1;
  localparam logic [1:0] REQ_START_RD = 2'd2;
  localparam logic [1:0] REQ_EVENT = 2'd3;

  // transfer mode codes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // bus actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_STOP = 3'd3;
  localparam logic [2:0] ACT_RECEIVE = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ARB_LOST = 2'd1;
  localparam logic [1:0] ERR_ADDR_NACK = 2'd2;

  typedef struct packed {
    logic [7:0] received_value;
    logic       no_ack;
    logic       arbitration_lost;
    logic [7:0] load_value;
    logic [4:0] load_index;
    logic       stop_at_end;
    logic [5:0] byte_count;
    logic [6:0] slave_address;
  } in_item_t;

  typedef struct packed {
    logic       transfer_complete;
    logic [1:0] error_code;
    logic       done_res;
    logic [7:0] rx_value;
    logic [4:0] rx_index;
    logic       rx_valid;
    logic       nack_next;
    logic [2:0] bus_action;
    logic [7:0] send_value;
    logic       send_valid;
  } out_item_t;

endpackage

// File: rtl/core/i2c_interrupt_transfer_sequencer_top.sv
// top level of the i2c interrupt transfer sequencer
// an input transaction passes the input register and then the result register before its result
// one item per cycle unless m_tready stalls; the tx buffer ram read is prefetched at the next byte position
// reset: clears mode, bus hold, counters, flags and both stream stages
// the tx buffer is not cleared and holds unknown data until loaded
module i2c_interrupt_transfer_sequencer_top #(
  parameter int BUFFER_DEPTH = i2cits_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slave_address, byte_count, stop_at_end, load_index, load_value,
  // arbitration_lost, no_ack, received_value, zero pad
  input  logic [39:0] s_tdata,
  // req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // send_valid, send_value, bus_action, nack_next, rx_valid, rx_index, rx_value,
  // done_res, error_code, transfer_complete, zero pad
  output logic [31:0] m_tdata
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = i2cits_pkg::CNT_W;

  // input register
  logic                  in_valid;
  logic [1:0]            in_req;
  i2cits_pkg::in_item_t  in_item;

  // result register
  logic                  out_valid;
  i2cits_pkg::out_item_t out_item;
  i2cits_pkg::out_item_t res;

  logic advance;
  logic out_free;

  // sequencer state
  logic [1:0]    transfer_mode, transfer_mode_next;
  logic          holds_bus, holds_bus_next;
  logic          address_phase, address_phase_next;
  logic [CW-1:0] target_count, target_count_next;
  logic [CW-1:0] byte_position, byte_position_next;
  logic          stop_flag, stop_flag_next;
  logic          notice_given, notice_given_next;
  logic          done_flag, done_flag_next;
  logic [1:0]    error_state, error_state_next;

  // tx buffer
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          fwd;
  logic [7:0]    fwd_value;
  logic [7:0]    tx_byte;

  logic [CW-1:0] cnt;
  logic [CW:0]   pos_plus2;
  logic          rd_req;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req  <= s_tuser;
      in_item <= s_tdata[36:0];
    end
  end

  assign wr_en   = advance && (in_req == i2cits_pkg::REQ_LOAD)
                   && (32'(in_item.load_index) < BUFFER_DEPTH);
  assign wr_addr = AW'(in_item.load_index);
  // prefetch the byte the next event would send
  assign rd_addr = AW'(byte_position_next);

  i2cits_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH),
    .AW   (AW)
  ) u_tx_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_item.load_value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // a load to the prefetched slot in the same cycle wins over the old ram data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_value <= in_item.load_value;
  end

  assign tx_byte   = fwd ? fwd_value : rd_data;
  assign rd_req    = (in_req == i2cits_pkg::REQ_START_RD);
  assign pos_plus2 = {1'b0, byte_position} + (CW+1)'(2);

  always_comb begin
    transfer_mode_next = transfer_mode;
    holds_bus_next     = holds_bus;
    address_phase_next = address_phase;
    target_count_next  = target_count;
    byte_position_next = byte_position;
    stop_flag_next     = stop_flag;
    notice_given_next  = notice_given;
    done_flag_next     = done_flag;
    error_state_next   = error_state;
    res                = '0;
    cnt                = in_item.byte_count;

    if (32'(in_item.byte_count) > BUFFER_DEPTH) begin
      cnt = CW'(BUFFER_DEPTH);
    end
    if (rd_req && (cnt == '0)) begin
      cnt = CW'(1);
    end

    if (advance) begin
      case (in_req)
        i2cits_pkg::REQ_LOAD: begin
        end
        i2cits_pkg::REQ_START_WR, i2cits_pkg::REQ_START_RD: begin
          transfer_mode_next = rd_req ? i2cits_pkg::MODE_READ : i2cits_pkg::MODE_WRITE;
          target_count_next  = cnt;
          byte_position_next = '0;
          stop_flag_next     = in_item.stop_at_end;
          notice_given_next  = 1'b0;
          done_flag_next     = 1'b0;
          error_state_next   = i2cits_pkg::ERR_NONE;
          address_phase_next = 1'b1;
          holds_bus_next     = 1'b1;
          res.bus_action     = holds_bus ? i2cits_pkg::ACT_RESTART : i2cits_pkg::ACT_START;
          res.send_valid     = 1'b1;
          res.send_value     = {in_item.slave_address, rd_req};
        end
        i2cits_pkg::REQ_EVENT: begin
          if (transfer_mode != i2cits_pkg::MODE_IDLE) begin
            if (in_item.arbitration_lost) begin
              error_state_next   = i2cits_pkg::ERR_ARB_LOST;
              done_flag_next     = 1'b1;
              holds_bus_next     = 1'b0;
              res.bus_action     = i2cits_pkg::ACT_STOP;
              transfer_mode_next = i2cits_pkg::MODE_IDLE;
            end else if (transfer_mode == i2cits_pkg::MODE_WRITE) begin
              address_phase_next = 1'b0;
              if (byte_position < target_count) begin
                res.send_valid     = 1'b1;
                res.send_value     = tx_byte;
                byte_position_next = byte_position + CW'(1);
              end else begin
                done_flag_next = 1'b1;
                if (stop_flag) begin
                  res.bus_action = i2cits_pkg::ACT_STOP;
                  holds_bus_next = 1'b0;
                end
                res.transfer_complete = !notice_given;
                notice_given_next     = 1'b1;
                transfer_mode_next    = i2cits_pkg::MODE_IDLE;
              end
            end else if (address_phase) begin
              if (!in_item.no_ack) begin
                address_phase_next = 1'b0;
                res.bus_action     = i2cits_pkg::ACT_RECEIVE;
                // one-byte read arms nack right away
                res.nack_next      = (target_count == CW'(1));
              end else begin
                error_state_next   = i2cits_pkg::ERR_ADDR_NACK;
                done_flag_next     = 1'b1;
                holds_bus_next     = 1'b0;
                res.bus_action     = i2cits_pkg::ACT_STOP;
                transfer_mode_next = i2cits_pkg::MODE_IDLE;
              end
            end else begin
              res.nack_next      = (pos_plus2 == {1'b0, target_count});
              res.rx_valid       = 1'b1;
              res.rx_index       = byte_position[4:0];
              res.rx_value       = in_item.received_value;
              byte_position_next = byte_position + CW'(1);
              if (byte_position_next >= target_count) begin
                done_flag_next = 1'b1;
                if (stop_flag) begin
                  res.bus_action = i2cits_pkg::ACT_STOP;
                  holds_bus_next = 1'b0;
                end
                res.transfer_complete = !notice_given;
                notice_given_next     = 1'b1;
                transfer_mode_next    = i2cits_pkg::MODE_IDLE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.done_res   = done_flag_next;
    res.error_code = error_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_mode <= i2cits_pkg::MODE_IDLE;
      holds_bus     <= 1'b0;
      address_phase <= 1'b0;
      target_count  <= '0;
      byte_position <= '0;
      stop_flag     <= 1'b0;
      notice_given  <= 1'b0;
      done_flag     <= 1'b0;
      error_state   <= i2cits_pkg::ERR_NONE;
    end else begin
      transfer_mode <= transfer_mode_next;
      holds_bus     <= holds_bus_next;
      address_phase <= address_phase_next;
      target_count  <= target_count_next;
      byte_position <= byte_position_next;
      stop_flag     <= stop_flag_next;
      notice_given  <= notice_given_next;
      done_flag     <= done_flag_next;
      error_state   <= error_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_item};

endmodule

// File: rtl/core/i2cits_ram.sv
// generic single-port-write ram with registered read
module i2cits_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
